/* sv/spq_pkg.sv */
package spq_pkg;

   localparam int CAPACITY         = 16;
   localparam int VALUE_BITS       = 16;
   localparam int PRIORITY_BITS    = 8;
   localparam int ENTRY_COUNT_BITS = $clog2(CAPACITY + 1);
   localparam int STATUS_BITS      = 2;

   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_POP    = 1'b1
   } action_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_INSERTED = 2'd0,
      ST_POPPED   = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      action_type               action;
      logic [VALUE_BITS-1:0]    item_value;
      logic [PRIORITY_BITS-1:0] item_priority;
   } req_type;

   typedef struct packed {
      status_type                  status;
      logic [VALUE_BITS-1:0]       popped_value;
      logic [ENTRY_COUNT_BITS-1:0] entry_count;
   } rsp_type;

   typedef enum logic {
      CTL_IDLE = 1'b0,
      CTL_EXEC = 1'b1
   } ctl_state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } dp_cmd_type;

endpackage

/* sv/spq_ctrl.sv */
module spq_ctrl
   import spq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd
);

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         CTL_IDLE: begin
            // a waiting result must leave by this edge before a new item enters
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_valid && req_ready) begin
               cmd.capture = 1'b1;
               state_in    = CTL_EXEC;
            end
         end
         CTL_EXEC: begin
            cmd.execute  = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = CTL_IDLE;
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* sv/spq_datapath.sv */
module spq_datapath
   import spq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  dp_cmd_type cmd,
   input  req_type    req_data,
   output rsp_type    rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [VALUE_BITS-1:0]    val_ff [CAPACITY];
   logic [VALUE_BITS-1:0]    val_in [CAPACITY];
   logic [PRIORITY_BITS-1:0] pri_ff [CAPACITY];
   logic [PRIORITY_BITS-1:0] pri_in [CAPACITY];
   logic [CNT_W-1:0]         count_ff, count_in;
   req_type                  op_ff;
   rsp_type                  rsp_ff, rsp_in;

   logic [CAPACITY-1:0] keep;
   logic                full, empty;

   assign full  = count_ff == CNT_W'(CAPACITY);
   assign empty = count_ff == '0;

   // cells ahead of the insert point hold entries of equal or higher priority
   always_comb begin
      for (int k = 0; k < CAPACITY; k++) begin
         keep[k] = (CNT_W'(k) < count_ff) && (pri_ff[k] >= op_ff.item_priority);
      end
   end

   always_comb begin
      val_in   = val_ff;
      pri_in   = pri_ff;
      count_in = count_ff;
      rsp_in   = rsp_ff;
      if (cmd.execute) begin
         rsp_in.popped_value = '0;
         if (op_ff.action == ACT_POP) begin
            if (empty) begin
               rsp_in.status = ST_EMPTY;
            end else begin
               // advance every cell toward the front
               for (int k = 0; k < CAPACITY - 1; k++) begin
                  val_in[k] = val_ff[k+1];
                  pri_in[k] = pri_ff[k+1];
               end
               count_in            = count_ff - CNT_W'(1);
               rsp_in.status       = ST_POPPED;
               rsp_in.popped_value = val_ff[0];
            end
         end else begin
            if (full) begin
               rsp_in.status = ST_FULL;
            end else begin
               if (!keep[0]) begin
                  val_in[0] = op_ff.item_value;
                  pri_in[0] = op_ff.item_priority;
               end
               for (int k = 1; k < CAPACITY; k++) begin
                  if (!keep[k]) begin
                     if (keep[k-1]) begin
                        val_in[k] = op_ff.item_value;
                        pri_in[k] = op_ff.item_priority;
                     end else begin
                        val_in[k] = val_ff[k-1];
                        pri_in[k] = pri_ff[k-1];
                     end
                  end
               end
               count_in      = count_ff + CNT_W'(1);
               rsp_in.status = ST_INSERTED;
            end
         end
         rsp_in.entry_count = ENTRY_COUNT_BITS'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      pri_ff <= pri_in;
      rsp_ff <= rsp_in;
      if (cmd.capture) begin
         op_ff <= req_data;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

/* sv/sorted_priority_queue_top.sv */
// Sorted priority queue of CAPACITY entries, highest priority at the front and
// equal priorities served in arrival order. An insert item places its value
// behind every stored entry of equal or higher priority across a row of
// compare-and-shift cells; a pop returns the front value and moves every
// cell forward. Each item gives exactly one result carrying the entry count
// after the item; an insert into a full queue is refused with status "insert on
// full" and a pop on an empty queue reports "pop on empty", both leaving the
// queue unchanged. One item is in flight at a time: the request is first
// captured into an operation register, then the cell row and the result
// register update together, and the next item is taken as the result
// register is freed. Stored values need no clearing after reset.
module sorted_priority_queue_top
   import spq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   dp_cmd_type cmd;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   spq_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

/* sv/spq_checker.sv */
module spq_checker
   import spq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
   else $error("result dropped before transfer");

   // one item in flight: no new transfer right after one
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
   else $error("input taken while an item is in flight");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 rsp_valid)
   else $error("result missing two cycles after input transfer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_EMPTY |->
         rsp_data.entry_count == '0 && rsp_data.popped_value == '0)
   else $error("pop on empty reports data or a count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_FULL || rsp_data.status == ST_INSERTED) |->
         rsp_data.popped_value == '0)
   else $error("insert result carries a popped value");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (.*);

/* test/tb_sorted_priority_queue_top.sv */
`timescale 1ns / 100ps

module tb_sorted_priority_queue_top;
   import spq_pkg::*;

   localparam int QUEUE_DEPTH       = CAPACITY;
   localparam int ITEMS_PER_PHASE   = 430;
   localparam int LONG_STALL_CYCLES = 80;
   localparam int DRAIN_CYCLES      = 10;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int tx_idle_pct;
   int rx_idle_pct;
   bit long_stall_request;

   // Sorted list predictor plus the queue of results it has promised.
   class queue_scoreboard;
      logic [VALUE_BITS-1:0]    slot_val[QUEUE_DEPTH];
      logic [PRIORITY_BITS-1:0] slot_pri[QUEUE_DEPTH];
      int unsigned              fill;
      rsp_type                  due[$];
      int unsigned              failures;
      int unsigned              accepted;
      int unsigned              pops;
      int unsigned              empty_pops;
      int unsigned              full_inserts;
      int unsigned              peak_fill;

      function new();
         fill         = 0;
         failures     = 0;
         accepted     = 0;
         pops         = 0;
         empty_pops   = 0;
         full_inserts = 0;
         peak_fill    = 0;
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         int      pos;
         e = '0;
         accepted++;
         if (r.action == ACT_POP) begin
            if (fill == 0) begin
               e.status = ST_EMPTY;
               empty_pops++;
            end else begin
               e.status       = ST_POPPED;
               e.popped_value = slot_val[0];
               for (int k = 1; k < fill; k++) begin
                  slot_val[k-1] = slot_val[k];
                  slot_pri[k-1] = slot_pri[k];
               end
               fill--;
               pops++;
            end
         end else begin
            if (fill >= QUEUE_DEPTH) begin
               e.status = ST_FULL;
               full_inserts++;
            end else begin
               // land behind every entry of equal or higher priority
               pos = 0;
               while (pos < fill && slot_pri[pos] >= r.item_priority)
                  pos++;
               for (int k = fill; k > pos; k--) begin
                  slot_val[k] = slot_val[k-1];
                  slot_pri[k] = slot_pri[k-1];
               end
               slot_val[pos] = r.item_value;
               slot_pri[pos] = r.item_priority;
               fill++;
               e.status = ST_INSERTED;
               if (fill > peak_fill)
                  peak_fill = fill;
            end
         end
         e.entry_count = ENTRY_COUNT_BITS'(fill);
         due.push_back(e);
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (due.size() == 0) begin
            failures++;
            $display("%0t: unexpected result: expected none, got status %0d value %h count %0d",
                     $time, got.status, got.popped_value, got.entry_count);
         end else begin
            e = due.pop_front();
            if (got.status !== e.status || got.popped_value !== e.popped_value ||
                got.entry_count !== e.entry_count) begin
               failures++;
               $display("%0t: expected status %0d value %h count %0d, %s",
                        $time, e.status, e.popped_value, e.entry_count,
                        $sformatf("got status %0d value %h count %0d",
                                  got.status, got.popped_value, got.entry_count));
            end
         end
      endfunction

      function int unsigned outstanding();
         return due.size();
      endfunction
   endclass

   queue_scoreboard sb;

   sorted_priority_queue_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic req_type make_req(action_type a, logic [VALUE_BITS-1:0] v,
                                        logic [PRIORITY_BITS-1:0] p);
      req_type r;
      r.action        = a;
      r.item_value    = v;
      r.item_priority = p;
      return r;
   endfunction

   // grow biases toward inserts, otherwise toward pops; a tenth is plain noise
   function automatic req_type random_req(bit grow);
      req_type r;
      if ($urandom_range(9) == 0)
         r.action = $urandom_range(1) ? ACT_POP : ACT_INSERT;
      else
         r.action = ($urandom_range(99) < (grow ? 80 : 20)) ? ACT_INSERT : ACT_POP;
      r.item_value = VALUE_BITS'($urandom_range(16'hFFFF));
      case ($urandom_range(3))
         0, 1: r.item_priority = PRIORITY_BITS'($urandom_range(3));
         2: begin
            case ($urandom_range(3))
               0: r.item_priority = 8'h00;
               1: r.item_priority = 8'hFF;
               2: r.item_priority = 8'h7F;
               default: r.item_priority = 8'h80;
            endcase
         end
         default: r.item_priority = PRIORITY_BITS'($urandom_range(255));
      endcase
      return r;
   endfunction

   // Offer one item and hold it until the transfer.
   task automatic send_item(req_type r);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0)
         @(posedge clock);
   endtask

   task automatic run_phase(int tx_pct, int rx_pct, bit with_stall);
      int burst_left;
      bit grow;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      burst_left  = 0;
      grow        = 1'b0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
         if (with_stall && i == ITEMS_PER_PHASE / 3)
            long_stall_request = 1'b1;
         if (burst_left == 0) begin
            grow       = ~grow;
            burst_left = $urandom_range(8, 40);
         end
         burst_left--;
         send_item(random_req(grow));
      end
      wait_drained();
   endtask

   initial begin
      sb                 = new();
      tx_idle_pct        = 0;
      rx_idle_pct        = 0;
      long_stall_request = 1'b0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty pop, field extremes, ties, fill up, refused insert, pops
      send_item(make_req(ACT_POP, 16'h0000, 8'h00));
      send_item(make_req(ACT_INSERT, 16'hFFFF, 8'h00));
      send_item(make_req(ACT_INSERT, 16'h0000, 8'hFF));
      send_item(make_req(ACT_INSERT, 16'h0001, 8'h80));
      send_item(make_req(ACT_INSERT, 16'h0002, 8'h80));
      send_item(make_req(ACT_INSERT, 16'h0003, 8'h80));
      for (int i = 0; i < 11; i++)
         send_item(make_req(ACT_INSERT, VALUE_BITS'(16'hA5A0 + i),
                            PRIORITY_BITS'((i % 3) * 64)));
      send_item(make_req(ACT_INSERT, 16'h5A5A, 8'hFF));
      send_item(make_req(ACT_POP, 16'hFFFF, 8'hFF));
      send_item(make_req(ACT_POP, 16'h0000, 8'h00));
      send_item(make_req(ACT_POP, 16'h1234, 8'h55));
      wait_drained();

      run_phase(7, 74, 1'b1);
      run_phase(74, 7, 1'b0);
      run_phase(0, 0, 1'b1);

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d items: %0d pops, %0d pops on empty, %0d inserts on full.",
               sb.accepted, sb.pops, sb.empty_pops, sb.full_inserts);
      $display("Peak fill %0d of %0d, with ties, stalls on both sides and a long output hold.",
               sb.peak_fill, QUEUE_DEPTH);
      if (sb.failures == 0 && sb.outstanding() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Result side: random stalls, plus a long hold when asked.
   initial begin
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (long_stall_request) begin
            long_stall_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_STALL_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
            @(posedge clock);
         end
      end
   end

   // A result at an edge always belongs to an earlier input, so check it first.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_data);
         if (req_valid && req_ready)
            sb.note_request(req_data);
      end
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
